@@ hdl/dbh_pkg.sv @@
package dbh_pkg;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned DurWidth   = 32;

  localparam logic [CfgWidth-1:0] DebounceReset   = 16'd20;
  localparam logic [CfgWidth-1:0] HoldRepeatReset = 16'd500;

  localparam logic CfgDebounce   = 1'b0;
  localparam logic CfgHoldRepeat = 1'b1;

  typedef enum logic [1:0] {
    EvNone     = 2'd0,
    EvPressed  = 2'd1,
    EvStill    = 2'd2,
    EvReleased = 2'd3
  } event_e;

  typedef struct packed {
    logic                  raw_level;
    logic                  acc_level;
    logic [CountWidth-1:0] since_update;
    logic                  change_pending;
    logic [CfgWidth-1:0]   hold_countdown;
    logic                  hold_active;
    logic [DurWidth-1:0]   hold_total;
  } state_t;

  typedef struct packed {
    event_e              event_res;
    logic [DurWidth-1:0] duration_ticks;
    logic                position;
  } result_t;

endpackage

@@ hdl/dbh_step.sv @@
module dbh_step (
  input  dbh_pkg::state_t                state_i,
  input  logic                           raw_i,
  input  logic [dbh_pkg::CfgWidth-1:0]   debounce_i,
  input  logic [dbh_pkg::CfgWidth-1:0]   hold_repeat_i,
  output dbh_pkg::state_t                state_o,
  output dbh_pkg::result_t               result_o
);

  logic [dbh_pkg::CountWidth-1:0] su_inc;
  logic                           raw_chg;
  logic                           db_done;
  logic                           try_acc;
  logic                           accepted;
  logic [dbh_pkg::CfgWidth-1:0]   period;
  logic [dbh_pkg::CfgWidth-1:0]   cd_dec;
  logic [dbh_pkg::DurWidth:0]     total_sum;
  logic [dbh_pkg::DurWidth-1:0]   total_sat;
  logic [63:0]                    su_ext;
  logic [dbh_pkg::DurWidth-1:0]   su_sat;

  always_comb begin
    su_inc    = (&state_i.since_update) ? state_i.since_update
                                        : state_i.since_update + 1'b1;
    raw_chg   = raw_i != state_i.raw_level;
    db_done   = su_inc >= dbh_pkg::CountWidth'(debounce_i);
    try_acc   = raw_chg ? db_done : (state_i.change_pending & db_done);
    accepted  = try_acc & (raw_i != state_i.acc_level);
    period    = (hold_repeat_i == '0) ? dbh_pkg::CfgWidth'(1) : hold_repeat_i;
    cd_dec    = (state_i.hold_countdown != '0) ? state_i.hold_countdown - 1'b1
                                               : state_i.hold_countdown;
    total_sum = {1'b0, state_i.hold_total} + (dbh_pkg::DurWidth+1)'(period);
    total_sat = total_sum[dbh_pkg::DurWidth] ? '1 : total_sum[dbh_pkg::DurWidth-1:0];
    su_ext    = 64'(su_inc);
    su_sat    = (su_ext > 64'hFFFF_FFFF) ? '1 : su_ext[dbh_pkg::DurWidth-1:0];
  end

  always_comb begin
    state_o                = state_i;
    state_o.raw_level      = raw_i;
    state_o.since_update   = su_inc;
    state_o.change_pending = try_acc ? 1'b0 : (raw_chg | state_i.change_pending);
    result_o.event_res      = dbh_pkg::EvNone;
    result_o.duration_ticks = '0;

    if (accepted) begin
      state_o.acc_level    = raw_i;
      state_o.since_update = '0;
      if (raw_i) begin
        result_o.event_res     = dbh_pkg::EvPressed;
        state_o.hold_total     = '0;
        state_o.hold_active    = 1'b1;
        state_o.hold_countdown = period;
      end else begin
        result_o.event_res      = dbh_pkg::EvReleased;
        result_o.duration_ticks = su_sat;
        state_o.hold_active     = 1'b0;
        state_o.hold_countdown  = '0;
      end
    end else if (state_i.hold_active) begin
      state_o.hold_countdown = cd_dec;
      if (cd_dec == '0) begin
        if (raw_i) begin
          state_o.hold_total      = total_sat;
          result_o.event_res      = dbh_pkg::EvStill;
          result_o.duration_ticks = total_sat;
          state_o.hold_countdown  = period;
        end else begin
          state_o.hold_active = 1'b0;
        end
      end
    end

    result_o.position = state_o.acc_level;
  end

endmodule

@@ hdl/button_debounce_hold_events_core.sv @@
// An accepted input beat reaches its output beat through the input register,
// then the tick logic into the result register.
// Throughput: one beat per cycle while m_axis_tready does not stall the output.
// Reset (rst_ni low, asynchronous): debounce state, hold timer and valid
// flags clear; debounce_ticks returns to 20 and hold_repeat_ticks to 500.
module button_debounce_hold_events_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] raw_pressed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] duration_ticks, [32] position
  output logic [1:0]  m_axis_tuser,   // [1:0] event_res
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [dbh_pkg::CfgWidth-1:0] debounce_q;
  logic [dbh_pkg::CfgWidth-1:0] hold_repeat_q;
  logic                         in_valid_q;
  logic                         raw_q;
  logic                         out_valid_q;
  logic                         out_ready;
  logic                         fire;
  dbh_pkg::state_t              state_q, state_d;
  dbh_pkg::result_t             res_q, res_d;

  assign out_ready     = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = ~in_valid_q | out_ready;
  assign fire          = in_valid_q & out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= dbh_pkg::DebounceReset;
      hold_repeat_q <= dbh_pkg::HoldRepeatReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dbh_pkg::CfgDebounce:   debounce_q    <= cfg_wdata_i;
        dbh_pkg::CfgHoldRepeat: hold_repeat_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      raw_q <= s_axis_tdata[0];
    end
  end

  dbh_step u_step (
    .state_i       (state_q),
    .raw_i         (raw_q),
    .debounce_i    (debounce_q),
    .hold_repeat_i (hold_repeat_q),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q <= state_d;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, res_q.position, res_q.duration_ticks};
  assign m_axis_tuser  = res_q.event_res;

  a_hold_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.hold_active |-> state_q.acc_level)
    else $error("hold timer running while released");

  a_idle_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.hold_active |-> (state_q.hold_countdown == '0))
    else $error("hold countdown left over after stop");

  a_still_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.event_res == dbh_pkg::EvStill ||
                     res_q.event_res == dbh_pkg::EvPressed))
      |-> res_q.position)
    else $error("press event with released position");

  a_release_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res_d.event_res == dbh_pkg::EvReleased) |=> !state_q.hold_active)
    else $error("hold timer survived release");

endmodule

@@ tb/sv/button_debounce_hold_events_core_tb.sv @@
`timescale 1ns / 1ps

module button_debounce_hold_events_core_tb;
  import dbh_pkg::*;

  typedef enum logic {
    RowTick,
    RowCfg
  } row_e;

  typedef struct packed {
    row_e          kind;
    logic          raw;
    logic [15:0]   deb;
    logic [15:0]   hold;
    logic          typed;
    event_e        ev;
    logic [31:0]   dur;
    logic          pos;
  } step_t;

  typedef struct packed {
    logic [15:0] deb;
    logic [15:0] hold;
    int          src_idle;
    int          sink_stall;
    int          items;
    int          span;
  } phase_t;

  localparam step_t Directed [32] = '{
    '{RowTick, 1'b0, 16'd0,     16'd0,     1'b1, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b1, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b0, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowCfg,  1'b0, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b1, 16'd0,     16'd0,     1'b1, EvPressed,  32'd0, 1'b1},
    '{RowTick, 1'b1, 16'd0,     16'd0,     1'b1, EvStill,    32'd1, 1'b1},
    '{RowTick, 1'b1, 16'd0,     16'd0,     1'b1, EvStill,    32'd2, 1'b1},
    '{RowTick, 1'b0, 16'd0,     16'd0,     1'b1, EvReleased, 32'd3, 1'b0},
    '{RowTick, 1'b0, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowCfg,  1'b0, 16'd3,     16'd65535, 1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b1, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b0, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b1, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b1, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b0, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b1, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b1, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b1, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowCfg,  1'b0, 16'd2,     16'd2,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b0, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b0, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b1, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b1, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b1, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b0, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowCfg,  1'b0, 16'd2,     16'd1,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b1, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b1, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b0, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b0, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0},
    '{RowCfg,  1'b0, 16'd65535, 16'd65535, 1'b0, EvNone,     32'd0, 1'b0},
    '{RowTick, 1'b1, 16'd0,     16'd0,     1'b0, EvNone,     32'd0, 1'b0}
  };

  localparam phase_t Phases [8] = '{
    '{16'd1,     16'd1,     0,  0,  250, 8},
    '{16'd0,     16'd0,     74, 0,  200, 6},
    '{16'd4,     16'd3,     0,  74, 250, 20},
    '{16'd8,     16'd5,     32, 32, 250, 30},
    '{16'd65535, 16'd1,     0,  0,  100, 10},
    '{16'd3,     16'd65535, 74, 0,  200, 15},
    '{16'd2,     16'd2,     0,  74, 250, 12},
    '{16'd6,     16'd4,     32, 32, 250, 25}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [0] raw_pressed
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // [31:0] duration_ticks, [32] position
  logic [1:0]  m_axis_tuser;         // [1:0] event_res
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = CfgDebounce;
  logic [15:0] cfg_wdata_i   = '0;

  logic [15:0]           deb_ticks  = DebounceReset;
  logic [15:0]           hold_ticks = HoldRepeatReset;
  logic                  seen_raw       = 1'b0;
  logic                  pos_level      = 1'b0;
  logic [CountWidth-1:0] ticks_since    = '0;
  logic                  change_waiting = 1'b0;
  logic [15:0]           hold_left      = '0;
  logic                  hold_on        = 1'b0;
  logic [DurWidth-1:0]   hold_sum       = '0;

  result_t events_due [$];
  int      mismatches     = 0;
  int      src_idle_pct   = 0;
  int      sink_stall_pct = 0;
  int      stall_left     = 0;

  button_debounce_hold_events_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic result_t debounce_tick(input logic raw);
    result_t     r;
    logic        try_accept;
    logic        accepted;
    logic [15:0] period;
    r          = '0;
    r.event_res = EvNone;
    try_accept = 1'b0;
    accepted   = 1'b0;
    period     = (hold_ticks == 16'd0) ? 16'd1 : hold_ticks;

    if (ticks_since != '1) ticks_since = ticks_since + 1'b1;

    if (raw != seen_raw) begin
      seen_raw = raw;
      if (ticks_since >= deb_ticks) try_accept = 1'b1;
      else change_waiting = 1'b1;
    end else if (change_waiting && ticks_since >= deb_ticks) begin
      try_accept = 1'b1;
    end

    if (try_accept) begin
      change_waiting = 1'b0;
      if (seen_raw != pos_level) begin
        accepted  = 1'b1;
        pos_level = seen_raw;
        if (pos_level) begin
          r.event_res = EvPressed;
          hold_sum    = '0;
          hold_on     = 1'b1;
          hold_left   = period;
        end else begin
          r.event_res      = EvReleased;
          r.duration_ticks = ticks_since;
          hold_on          = 1'b0;
          hold_left        = '0;
        end
        ticks_since = '0;
      end
    end

    if (!accepted && hold_on) begin
      if (hold_left != '0) hold_left = hold_left - 1'b1;
      if (hold_left == '0) begin
        if (seen_raw) begin
          if (hold_sum > 32'hFFFF_FFFF - period) hold_sum = '1;
          else hold_sum = hold_sum + period;
          r.event_res      = EvStill;
          r.duration_ticks = hold_sum;
          hold_left        = period;
        end else begin
          hold_on = 1'b0;
        end
      end
    end

    r.position = pos_level;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic send_tick(input logic raw, input bit typed = 1'b0,
                           input result_t want = '0);
    result_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, raw};
    do @(posedge clk_i); while (!s_axis_tready);
    r = debounce_tick(raw);
    if (typed) r = want;
    events_due = {events_due, r};
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [15:0] deb, input logic [15:0] hold);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgDebounce;
    cfg_wdata_i <= deb;
    @(negedge clk_i);
    cfg_idx_i   <= CfgHoldRepeat;
    cfg_wdata_i <= hold;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    deb_ticks  = deb;
    hold_ticks = hold;
  endtask

  // bounce first, then settle at the new level
  task automatic send_gesture(input logic level, input int span, inout int sent);
    int n_bounce;
    int n_hold;
    n_bounce = $urandom_range(4, 0);
    n_hold   = $urandom_range(span, 1);
    repeat (n_bounce) send_tick(1'($urandom_range(1, 0)));
    repeat (n_hold) send_tick(level);
    sent += n_bounce + n_hold;
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_beats
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (events_due.size() == 0) begin
        flag_mismatch("result beat with nothing expected");
      end else begin
        want = events_due.pop_front();
        if (m_axis_tuser !== want.event_res)
          flag_mismatch($sformatf("event_res got %0d want %0d",
                                  m_axis_tuser, want.event_res));
        if (m_axis_tdata[31:0] !== want.duration_ticks)
          flag_mismatch($sformatf("duration_ticks got %0d want %0d",
                                  m_axis_tdata[31:0], want.duration_ticks));
        if (m_axis_tdata[32] !== want.position)
          flag_mismatch($sformatf("position got %0b want %0b",
                                  m_axis_tdata[32], want.position));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int      sent;
    int      n;
    logic    level;
    bit      paused;
    result_t want;
    level = 1'b1;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (Directed[i]) begin
      if (Directed[i].kind == RowCfg) begin
        wait_idle();
        write_cfg(Directed[i].deb, Directed[i].hold);
      end else begin
        want                = '0;
        want.event_res      = Directed[i].ev;
        want.duration_ticks = Directed[i].dur;
        want.position       = Directed[i].pos;
        send_tick(Directed[i].raw, Directed[i].typed, want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_cfg(Phases[p].deb, Phases[p].hold);
      src_idle_pct   = Phases[p].src_idle;
      sink_stall_pct = Phases[p].sink_stall;
      if (p == 0) stall_left = 80;
      sent   = 0;
      paused = 1'b0;
      while (sent < Phases[p].items) begin
        if (p == 2 && !paused && sent >= Phases[p].items / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 15) begin
          n = $urandom_range(6, 1);
          repeat (n) send_tick(1'($urandom_range(1, 0)));
          sent += n;
        end else begin
          send_gesture(level, Phases[p].span, sent);
          level = ~level;
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
